// ===== src/sct_pkg.sv =====
// Shared constants, types and helpers for the sprite corner transform core.
package sct_pkg;

  localparam int unsigned COORD_W        = 32;
  localparam int unsigned DIM_W          = 16;
  localparam int unsigned ANGLE_W        = 16;
  localparam int unsigned ANGLE_BITS     = 16;
  localparam int unsigned TRIG_FRAC_BITS = 16;

  // CORDIC datapath: Q30 x/y, 1/2^32-turn z, 33 bits covers all three
  localparam int unsigned CORDIC_STEPS = 25;
  localparam int unsigned CORDIC_W     = 33;
  localparam int unsigned TRIG_SHIFT   = 30 - TRIG_FRAC_BITS;
  localparam int unsigned TRIG_W       = TRIG_FRAC_BITS + 2;

  // Rotation datapath widths
  localparam int unsigned PROD_W = COORD_W + TRIG_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned ROT_W  = SUM_W - TRIG_FRAC_BITS;
  localparam int unsigned SAT_W  = ROT_W + 1;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [CORDIC_W-1:0] TRIG_HALF   = CORDIC_W'(64'd1 << (TRIG_SHIFT - 1));
  localparam logic signed [SUM_W-1:0]    ROT_HALF    = SUM_W'(64'd1 << (TRIG_FRAC_BITS - 1));

  localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh80000000;

  // atan(2^-i) in 1/2^32 turns
  localparam logic [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    33'd536870912, 33'd316933406, 33'd167458907, 33'd85004756, 33'd42667331,
    33'd21354465,  33'd10679838,  33'd5340245,   33'd2670163,  33'd1335087,
    33'd667544,    33'd333772,    33'd166886,    33'd83443,    33'd41722,
    33'd20861,     33'd10430,     33'd5215,      33'd2608,     33'd1304,
    33'd652,       33'd326,       33'd163,       33'd81,       33'd41
  };

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  // Sprite data that rides along the CORDIC pipeline
  typedef struct packed {
    logic                      req_type;
    logic                      zero;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] position_x;
    logic signed [COORD_W-1:0] position_y;
    logic signed [COORD_W-1:0] side_w;
    logic signed [COORD_W-1:0] side_h;
  } side_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[SAT_W-1:COORD_W-1];
    all_zero = ~|v[SAT_W-1:COORD_W-1];
    if (all_one || all_zero) begin
      return v[COORD_W-1:0];
    end
    return v[SAT_W-1] ? S32_MIN : S32_MAX;
  endfunction

endpackage

// ===== src/sct_in_if.sv =====
// Sprite descriptor channel: valid/ready handshake plus descriptor fields.
interface sct_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic signed [sct_pkg::COORD_W-1:0]    origin_x;
  logic signed [sct_pkg::COORD_W-1:0]    origin_y;
  logic signed [sct_pkg::COORD_W-1:0]    position_x;
  logic signed [sct_pkg::COORD_W-1:0]    position_y;
  logic        [sct_pkg::DIM_W-1:0]      rect_w;
  logic        [sct_pkg::DIM_W-1:0]      rect_h;
  logic        [sct_pkg::DIM_W-1:0]      scale;
  logic        [sct_pkg::ANGLE_W-1:0]    angle;

  modport source (
    output valid, req_type, origin_x, origin_y, position_x, position_y,
           rect_w, rect_h, scale, angle,
    input  ready
  );

  modport sink (
    input  valid, req_type, origin_x, origin_y, position_x, position_y,
           rect_w, rect_h, scale, angle,
    output ready
  );
endinterface

// ===== src/sct_out_if.sv =====
// Point channel: valid/ready handshake plus one transformed point.
interface sct_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sct_pkg::COORD_W-1:0] point_x;
  logic signed [sct_pkg::COORD_W-1:0] point_y;
  logic        [1:0]                  point_index;
  logic                               last;

  modport source (
    output valid, point_x, point_y, point_index, last,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_index, last,
    output ready
  );
endinterface

// ===== src/sct_cordic.sv =====
// Fully pipelined CORDIC: one rotation step per stage, then rounding and quadrant fold.
module sct_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [sct_pkg::ANGLE_BITS-1:0]         angle_i,
  input  sct_pkg::side_t                         side_i,
  output logic                                   valid_o,
  output logic signed [sct_pkg::TRIG_W-1:0]      cos_o,
  output logic signed [sct_pkg::TRIG_W-1:0]      sin_o,
  output sct_pkg::side_t                         side_o
);

  localparam int unsigned N = sct_pkg::CORDIC_STEPS;
  localparam int unsigned W = sct_pkg::CORDIC_W;

  logic [31:0] a32;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  sct_pkg::quad_e      quad_q [N+1];
  sct_pkg::side_t      side_q [N+1];
  logic [N:0]          vld_q;

  logic signed [W-1:0]                c_full, s_full;
  logic signed [sct_pkg::TRIG_W-1:0]  c_rnd, s_rnd;
  logic signed [sct_pkg::TRIG_W-1:0]  cos_d, sin_d;

  logic                               out_vld_q;
  logic signed [sct_pkg::TRIG_W-1:0]  cos_q, sin_q;
  sct_pkg::side_t                     side_out_q;

  assign a32 = {angle_i, {(32 - sct_pkg::ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= sct_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({{(W - 30){1'b0}}, a32[29:0]});
      quad_q[0] <= sct_pkg::quad_e'(a32[31:30]);
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed(sct_pkg::ATAN_TURNS[i]);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed(sct_pkg::ATAN_TURNS[i]);
        end
        quad_q[i+1] <= quad_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[N-1:0], valid_i};
      out_vld_q <= vld_q[N];
    end
  end

  // Round half up from Q30 to the trig fraction, then undo the quadrant fold
  always_comb begin
    c_full = (x_q[N] + sct_pkg::TRIG_HALF) >>> sct_pkg::TRIG_SHIFT;
    s_full = (y_q[N] + sct_pkg::TRIG_HALF) >>> sct_pkg::TRIG_SHIFT;
    c_rnd  = c_full[sct_pkg::TRIG_W-1:0];
    s_rnd  = s_full[sct_pkg::TRIG_W-1:0];
    case (quad_q[N])
      sct_pkg::QUAD_0: begin
        cos_d = c_rnd;
        sin_d = s_rnd;
      end
      sct_pkg::QUAD_90: begin
        cos_d = -s_rnd;
        sin_d = c_rnd;
      end
      sct_pkg::QUAD_180: begin
        cos_d = -c_rnd;
        sin_d = -s_rnd;
      end
      sct_pkg::QUAD_270: begin
        cos_d = s_rnd;
        sin_d = -c_rnd;
      end
      default: begin
        cos_d = c_rnd;
        sin_d = s_rnd;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q      <= cos_d;
      sin_q      <= sin_d;
      side_out_q <= side_q[N];
    end
  end

  assign valid_o = out_vld_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = side_out_q;

endmodule

// ===== src/sprite_corner_transform_core.sv =====
// Sprite corner transform core: scale, rotate and translate sprite corners.
//
// A sprite descriptor can be taken in every cycle while the sprite pipeline has
// room; each descriptor yields four corner points (req_type 0) or two bounding
// square points (req_type 1), delivered one point per cycle while point_o is
// ready. The sustained sprite rate is therefore set by the single point lane,
// which takes the next sprite only with the last point of the previous one and
// follows the per-sprite pipeline (four multipliers shared by all points of a
// sprite). Toward the first point a descriptor passes one multiply stage, 27
// CORDIC stages, one box stage, the point serializer and three point stages.
module sprite_corner_transform_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sct_in_if.sink    sprite_i,
  sct_out_if.source point_o
);

  localparam int unsigned CW = sct_pkg::COORD_W;

  localparam logic [1:0] LAST_IDX_BOX    = 2'd3;
  localparam logic [1:0] LAST_IDX_SQUARE = 2'd1;

  typedef struct packed {
    logic                              req_type;
    logic                              rot;
    logic signed [sct_pkg::TRIG_W-1:0] cos_v;
    logic signed [sct_pkg::TRIG_W-1:0] sin_v;
    logic signed [CW-1:0]              x_lo;
    logic signed [CW-1:0]              x_hi;
    logic signed [CW-1:0]              y_lo;
    logic signed [CW-1:0]              y_hi;
    logic signed [CW-1:0]              off_x;
    logic signed [CW-1:0]              off_y;
  } item_t;

  logic en_f, en_b, ser_take;

  // ---------------- multiply stage ----------------
  logic                              m_vld_q;
  logic                              m_req_q;
  logic signed [CW-1:0]              m_ox_q, m_oy_q, m_px_q, m_py_q;
  logic [31:0]                       m_prod_w_q, m_prod_h_q;
  logic [sct_pkg::ANGLE_BITS-1:0]    m_ang_q;
  sct_pkg::side_t                    m_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en_f) begin
      m_vld_q <= sprite_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f) begin
      m_req_q    <= sprite_i.req_type;
      m_ox_q     <= sprite_i.origin_x;
      m_oy_q     <= sprite_i.origin_y;
      m_px_q     <= sprite_i.position_x;
      m_py_q     <= sprite_i.position_y;
      m_prod_w_q <= 32'(sprite_i.rect_w) * 32'(sprite_i.scale);
      m_prod_h_q <= 32'(sprite_i.rect_h) * 32'(sprite_i.scale);
      m_ang_q    <= sprite_i.angle[sct_pkg::ANGLE_W-1 -: sct_pkg::ANGLE_BITS];
    end
  end

  // side = product << 8 in Q16.16, clamped at the signed maximum
  always_comb begin
    m_side.req_type   = m_req_q;
    m_side.zero       = (m_ang_q == '0);
    m_side.origin_x   = m_ox_q;
    m_side.origin_y   = m_oy_q;
    m_side.position_x = m_px_q;
    m_side.position_y = m_py_q;
    m_side.side_w     = (|m_prod_w_q[31:23]) ? sct_pkg::S32_MAX
                                             : {1'b0, m_prod_w_q[22:0], 8'h00};
    m_side.side_h     = (|m_prod_h_q[31:23]) ? sct_pkg::S32_MAX
                                             : {1'b0, m_prod_h_q[22:0], 8'h00};
  end

  // ---------------- sine / cosine ----------------
  logic                              c_vld;
  logic signed [sct_pkg::TRIG_W-1:0] c_cos, c_sin;
  sct_pkg::side_t                    c_side;

  sct_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_f),
    .valid_i (m_vld_q),
    .angle_i (m_ang_q),
    .side_i  (m_side),
    .valid_o (c_vld),
    .cos_o   (c_cos),
    .sin_o   (c_sin),
    .side_o  (c_side)
  );

  // ---------------- box stage ----------------
  logic                 b_vld_q;
  item_t                b_q, b_d;
  logic signed [CW-1:0] bx_right, by_bottom, bx0, by0, b_side;

  always_comb begin
    bx_right  = sct_pkg::sat32(sct_pkg::SAT_W'(c_side.origin_x)
                               + sct_pkg::SAT_W'(c_side.side_w));
    by_bottom = sct_pkg::sat32(sct_pkg::SAT_W'(c_side.origin_y)
                               + sct_pkg::SAT_W'(c_side.side_h));
    bx0       = sct_pkg::sat32(sct_pkg::SAT_W'(c_side.origin_x)
                               + sct_pkg::SAT_W'(c_side.position_x));
    by0       = sct_pkg::sat32(sct_pkg::SAT_W'(c_side.origin_y)
                               + sct_pkg::SAT_W'(c_side.position_y));
    b_side    = (c_side.side_w > c_side.side_h) ? c_side.side_w : c_side.side_h;

    b_d.req_type = c_side.req_type;
    b_d.rot      = !c_side.req_type && !c_side.zero;
    b_d.cos_v    = c_cos;
    b_d.sin_v    = c_sin;
    if (c_side.req_type) begin
      // bounding square: second point adds the larger side to the first
      b_d.x_lo  = bx0;
      b_d.x_hi  = b_side;
      b_d.y_lo  = by0;
      b_d.y_hi  = b_side;
      b_d.off_x = bx0;
      b_d.off_y = by0;
    end else begin
      b_d.x_lo  = c_side.origin_x;
      b_d.x_hi  = bx_right;
      b_d.y_lo  = c_side.origin_y;
      b_d.y_hi  = by_bottom;
      b_d.off_x = c_side.position_x;
      b_d.off_y = c_side.position_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_f) begin
      b_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f) begin
      b_q <= b_d;
    end
  end

  // ---------------- point serializer ----------------
  logic                 s_vld_q;
  item_t                s_q;
  logic [1:0]           s_k_q;
  logic                 s_last;
  logic                 s_ysel, s_off_zero;
  logic signed [CW-1:0] s_x, s_y, s_off_x, s_off_y;

  assign s_last   = s_q.req_type ? (s_k_q == LAST_IDX_SQUARE) : (s_k_q == LAST_IDX_BOX);
  assign ser_take = en_b && (!s_vld_q || s_last);
  assign en_f     = !b_vld_q || ser_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
      s_k_q   <= '0;
    end else if (en_b) begin
      if (ser_take) begin
        s_vld_q <= b_vld_q;
        s_k_q   <= '0;
      end else begin
        s_k_q   <= s_k_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take) begin
      s_q <= b_q;
    end
  end

  always_comb begin
    s_ysel     = s_q.req_type ? s_k_q[0] : s_k_q[1];
    s_off_zero = s_q.req_type && !s_k_q[0];
    s_x        = s_k_q[0] ? s_q.x_hi : s_q.x_lo;
    s_y        = s_ysel ? s_q.y_hi : s_q.y_lo;
    s_off_x    = s_off_zero ? '0 : s_q.off_x;
    s_off_y    = s_off_zero ? '0 : s_q.off_y;
  end

  // ---------------- point stage 1: products ----------------
  logic                                r1_vld_q;
  logic signed [CW-1:0]                r1_x_q, r1_y_q, r1_off_x_q, r1_off_y_q;
  logic                                r1_rot_q, r1_last_q;
  logic [1:0]                          r1_idx_q;
  logic signed [sct_pkg::PROD_W-1:0]   r1_xc_q, r1_ys_q, r1_xs_q, r1_yc_q;

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      r1_x_q     <= s_x;
      r1_y_q     <= s_y;
      r1_off_x_q <= s_off_x;
      r1_off_y_q <= s_off_y;
      r1_rot_q   <= s_q.rot;
      r1_last_q  <= s_last;
      r1_idx_q   <= s_k_q;
      r1_xc_q    <= sct_pkg::PROD_W'(s_x) * sct_pkg::PROD_W'(s_q.cos_v);
      r1_ys_q    <= sct_pkg::PROD_W'(s_y) * sct_pkg::PROD_W'(s_q.sin_v);
      r1_xs_q    <= sct_pkg::PROD_W'(s_x) * sct_pkg::PROD_W'(s_q.sin_v);
      r1_yc_q    <= sct_pkg::PROD_W'(s_y) * sct_pkg::PROD_W'(s_q.cos_v);
    end
  end

  // ---------------- point stage 2: rotate and round ----------------
  logic                                r2_vld_q;
  logic signed [sct_pkg::SUM_W-1:0]    sum_x, sum_y;
  logic signed [sct_pkg::SUM_W-1:0]    shr_x, shr_y;
  logic signed [sct_pkg::ROT_W-1:0]    r2_x_d, r2_y_d;
  logic signed [sct_pkg::ROT_W-1:0]    r2_x_q, r2_y_q;
  logic signed [CW-1:0]                r2_off_x_q, r2_off_y_q;
  logic                                r2_last_q;
  logic [1:0]                          r2_idx_q;

  always_comb begin
    sum_x  = sct_pkg::SUM_W'(r1_xc_q) - sct_pkg::SUM_W'(r1_ys_q) + sct_pkg::ROT_HALF;
    sum_y  = sct_pkg::SUM_W'(r1_xs_q) + sct_pkg::SUM_W'(r1_yc_q) + sct_pkg::ROT_HALF;
    shr_x  = sum_x >>> sct_pkg::TRIG_FRAC_BITS;
    shr_y  = sum_y >>> sct_pkg::TRIG_FRAC_BITS;
    r2_x_d = r1_rot_q ? shr_x[sct_pkg::ROT_W-1:0] : sct_pkg::ROT_W'(r1_x_q);
    r2_y_d = r1_rot_q ? shr_y[sct_pkg::ROT_W-1:0] : sct_pkg::ROT_W'(r1_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      r2_x_q     <= r2_x_d;
      r2_y_q     <= r2_y_d;
      r2_off_x_q <= r1_off_x_q;
      r2_off_y_q <= r1_off_y_q;
      r2_last_q  <= r1_last_q;
      r2_idx_q   <= r1_idx_q;
    end
  end

  // ---------------- point stage 3: translate, output register ----------------
  logic                 o_vld_q;
  logic signed [CW-1:0] o_x_q, o_y_q;
  logic [1:0]           o_idx_q;
  logic                 o_last_q;

  assign en_b = !o_vld_q || point_o.ready;

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      o_x_q    <= sct_pkg::sat32(sct_pkg::SAT_W'(r2_off_x_q) + sct_pkg::SAT_W'(r2_x_q));
      o_y_q    <= sct_pkg::sat32(sct_pkg::SAT_W'(r2_off_y_q) + sct_pkg::SAT_W'(r2_y_q));
      o_idx_q  <= r2_idx_q;
      o_last_q <= r2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (en_b) begin
      r1_vld_q <= s_vld_q;
      r2_vld_q <= r1_vld_q;
      o_vld_q  <= r2_vld_q;
    end
  end

  assign sprite_i.ready      = en_f;
  assign point_o.valid       = o_vld_q;
  assign point_o.point_x     = o_x_q;
  assign point_o.point_y     = o_y_q;
  assign point_o.point_index = o_idx_q;
  assign point_o.last        = o_last_q;

  // ---------------- assertions ----------------
  // last only closes a square (index 1) or a box (index 3)
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_last_q) |-> (o_idx_q == LAST_IDX_SQUARE || o_idx_q == LAST_IDX_BOX))
    else $error("last flag on an unexpected point index");

  // points of one sprite leave back to back with rising index
  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && point_o.ready && !o_last_q) |=>
      (o_vld_q && o_idx_q == $past(o_idx_q) + 2'd1))
    else $error("gap or index jump inside a sprite's points");

  // a bounding-square request never counts past its second point
  a_square_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_vld_q && s_q.req_type) |-> (s_k_q <= LAST_IDX_SQUARE))
    else $error("serializer overran a bounding-square request");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the sprite corner transform core.
module tb;

  localparam int unsigned ANGLE_Q   = sct_pkg::ANGLE_BITS;
  localparam int unsigned TRIG_Q    = sct_pkg::TRIG_FRAC_BITS;
  localparam int          N_RANDOM  = 160;
  localparam longint      COORD_MAX = 64'sd2147483647;
  localparam longint      COORD_MIN = -64'sd2147483648;
  localparam longint      GAIN_Q30  = 64'sd652032874;

  typedef struct {
    logic                               req_type;
    logic signed [sct_pkg::COORD_W-1:0] origin_x;
    logic signed [sct_pkg::COORD_W-1:0] origin_y;
    logic signed [sct_pkg::COORD_W-1:0] position_x;
    logic signed [sct_pkg::COORD_W-1:0] position_y;
    logic        [sct_pkg::DIM_W-1:0]   rect_w;
    logic        [sct_pkg::DIM_W-1:0]   rect_h;
    logic        [sct_pkg::DIM_W-1:0]   scale;
    logic        [sct_pkg::ANGLE_W-1:0] angle;
  } sprite_t;

  typedef struct {
    logic signed [sct_pkg::COORD_W-1:0] x;
    logic signed [sct_pkg::COORD_W-1:0] y;
    logic        [1:0]                  index;
    logic                               last;
  } point_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sct_in_if  sprite_if ();
  sct_out_if point_if ();

  sprite_corner_transform_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sprite_i (sprite_if),
    .point_o  (point_if)
  );

  sprite_t     pending_sprites[$];
  point_t      expected_points[$];
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned sprites_taken;
  int unsigned points_seen;
  int          errors = 0;
  sprite_t     seen;

  always #4 clk_i = ~clk_i;

  function automatic longint clip32(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // atan(2^-i) in 1/2^32 turns
  function automatic longint arctan_step(input int i);
    case (i)
      0:  return 536870912;  1:  return 316933406;  2:  return 167458907;
      3:  return 85004756;   4:  return 42667331;   5:  return 21354465;
      6:  return 10679838;   7:  return 5340245;    8:  return 2670163;
      9:  return 1335087;    10: return 667544;     11: return 333772;
      12: return 166886;     13: return 83443;      14: return 41722;
      15: return 20861;      16: return 10430;      17: return 5215;
      18: return 2608;       19: return 1304;       20: return 652;
      21: return 326;        22: return 163;        23: return 81;
      default: return 41;
    endcase
  endfunction

  // cos/sin of a 1/2^32-turn angle, in Q(TRIG_Q)
  function automatic void cordic_trig(input logic [31:0] turn, output longint cs,
                                      output longint sn);
    longint x, y, z, dx, dy, c, s;
    int     i;
    x = GAIN_Q30;
    y = 0;
    z = longint'(turn[29:0]);
    for (i = 0; i < 25; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    c = round_half_up(x, 30 - TRIG_Q);
    s = round_half_up(y, 30 - TRIG_Q);
    case (sct_pkg::quad_e'(turn[31:30]))
      sct_pkg::QUAD_0:   begin cs = c;  sn = s;  end
      sct_pkg::QUAD_90:  begin cs = -s; sn = c;  end
      sct_pkg::QUAD_180: begin cs = -c; sn = -s; end
      default:           begin cs = s;  sn = -c; end
    endcase
  endfunction

  function automatic void add_point(input int k, input longint x, input longint y,
                                    input logic last);
    point_t p;
    p.x     = x[31:0];
    p.y     = y[31:0];
    p.index = k[1:0];
    p.last  = last;
    expected_points.push_back(p);
  endfunction

  function automatic void transform_sprite(input sprite_t s);
    longint             ox, oy, px, py, sw, sh, side, x0, y0, cs, sn, x, y, nx, ny;
    longint             cx[4], cy[4];
    logic [ANGLE_Q-1:0] ang_q;
    logic [31:0]        turn;
    int                 k;
    ox = longint'(s.origin_x);
    oy = longint'(s.origin_y);
    px = longint'(s.position_x);
    py = longint'(s.position_y);
    sw = clip32((longint'(s.rect_w) * longint'(s.scale)) <<< 8);
    sh = clip32((longint'(s.rect_h) * longint'(s.scale)) <<< 8);
    if (s.req_type) begin
      side = (sw > sh) ? sw : sh;
      x0 = clip32(ox + px);
      y0 = clip32(oy + py);
      add_point(0, x0, y0, 1'b0);
      add_point(1, clip32(x0 + side), clip32(y0 + side), 1'b1);
    end else begin
      cx[0] = ox;              cy[0] = oy;
      cx[1] = clip32(ox + sw); cy[1] = oy;
      cx[2] = ox;              cy[2] = clip32(oy + sh);
      cx[3] = cx[1];           cy[3] = cy[2];
      ang_q = s.angle >> (sct_pkg::ANGLE_W - ANGLE_Q);
      turn  = 32'(ang_q) << (32 - ANGLE_Q);
      cs = 0;
      sn = 0;
      if (ang_q != 0) cordic_trig(turn, cs, sn);
      for (k = 0; k < 4; k++) begin
        x = cx[k];
        y = cy[k];
        // zero angle: translate only
        if (ang_q != 0) begin
          nx = round_half_up(x * cs - y * sn, TRIG_Q);
          ny = round_half_up(x * sn + y * cs, TRIG_Q);
          x = nx;
          y = ny;
        end
        add_point(k, clip32(px + x), clip32(py + y), k == 3);
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sprite_t mk(input logic req, input longint ox, input longint oy,
                                 input longint px, input longint py, input int rw,
                                 input int rh, input int sc, input int ang);
    sprite_t s;
    s.req_type   = req;
    s.origin_x   = ox[31:0];
    s.origin_y   = oy[31:0];
    s.position_x = px[31:0];
    s.position_y = py[31:0];
    s.rect_w     = rw[15:0];
    s.rect_h     = rh[15:0];
    s.scale      = sc[15:0];
    s.angle      = ang[15:0];
    return s;
  endfunction

  function automatic longint edge_coord();
    case ($urandom_range(0, 4))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return 0;
      3:       return -1;
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  function automatic int edge_dim();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 65535;
      2:       return 1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic longint near_coord(input int bits);
    return longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
  endfunction

  // sprite source: one transaction at a time, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_if.valid <= 1'b0;
      send_gap        <= 0;
      sprites_taken   <= 0;
    end else begin
      if (sprite_if.valid && sprite_if.ready) begin
        seen.req_type   = sprite_if.req_type;
        seen.origin_x   = sprite_if.origin_x;
        seen.origin_y   = sprite_if.origin_y;
        seen.position_x = sprite_if.position_x;
        seen.position_y = sprite_if.position_y;
        seen.rect_w     = sprite_if.rect_w;
        seen.rect_h     = sprite_if.rect_h;
        seen.scale      = sprite_if.scale;
        seen.angle      = sprite_if.angle;
        transform_sprite(seen);
        sprites_taken <= sprites_taken + 1;
      end
      if (!sprite_if.valid || sprite_if.ready) begin
        if (send_gap != 0) begin
          sprite_if.valid <= 1'b0;
          send_gap        <= send_gap - 1;
        end else if (pending_sprites.size() != 0) begin
          seen = pending_sprites.pop_front();
          sprite_if.req_type   <= seen.req_type;
          sprite_if.origin_x   <= seen.origin_x;
          sprite_if.origin_y   <= seen.origin_y;
          sprite_if.position_x <= seen.position_x;
          sprite_if.position_y <= seen.position_y;
          sprite_if.rect_w     <= seen.rect_w;
          sprite_if.rect_h     <= seen.rect_h;
          sprite_if.scale      <= seen.scale;
          sprite_if.angle      <= seen.angle;
          sprite_if.valid      <= 1'b1;
          // back-to-back stretch every few dozen sprites
          send_gap <= (sprites_taken[5:4] == 2'b11) ? 0 : pick_gap();
        end else begin
          sprite_if.valid <= 1'b0;
        end
      end
    end
  end

  // point sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_if.ready <= 1'b0;
      recv_stall     <= 0;
      points_seen    <= 0;
    end else begin
      if (point_if.valid && point_if.ready) begin
        points_seen <= points_seen + 1;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d idx=%0d last=%0b", $time,
                   point_if.point_x, point_if.point_y, point_if.point_index, point_if.last);
          errors++;
        end else begin
          if (point_if.point_x !== expected_points[0].x ||
              point_if.point_y !== expected_points[0].y ||
              point_if.point_index !== expected_points[0].index ||
              point_if.last !== expected_points[0].last) begin
            $display({"%0t: point mismatch: expected x=%0d y=%0d idx=%0d last=%0b,",
                      " got x=%0d y=%0d idx=%0d last=%0b"},
                     $time, expected_points[0].x, expected_points[0].y,
                     expected_points[0].index, expected_points[0].last,
                     point_if.point_x, point_if.point_y, point_if.point_index,
                     point_if.last);
            errors++;
          end
          void'(expected_points.pop_front());
        end
      end
      if (recv_stall != 0) begin
        point_if.ready <= 1'b0;
        recv_stall     <= recv_stall - 1;
      end else begin
        point_if.ready <= 1'b1;
        recv_stall     <= (points_seen[6:5] == 2'b01) ? 0 : pick_gap();
      end
    end
  end

  initial begin
    sprite_t s;
    int      n, r;
    sprite_if.valid      = 1'b0;
    sprite_if.req_type   = 1'b0;
    sprite_if.origin_x   = '0;
    sprite_if.origin_y   = '0;
    sprite_if.position_x = '0;
    sprite_if.position_y = '0;
    sprite_if.rect_w     = '0;
    sprite_if.rect_h     = '0;
    sprite_if.scale      = '0;
    sprite_if.angle      = '0;
    point_if.ready       = 1'b0;

    // directed: quadrants, tiny angles, saturation corners, degenerate sizes
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 16, 8, 256, 16'h0000));
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 16, 8, 256, 16'h4000));
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 16, 8, 256, 16'h8000));
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 16, 8, 256, 16'hC000));
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 16, 8, 256, 16'h0001));
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 16, 8, 256, 16'hFFFF));
    pending_sprites.push_back(mk(0, -(8 << 16), -(4 << 16), 100 << 16, 50 << 16, 16, 8, 512,
                                 16'h2000));
    pending_sprites.push_back(mk(1, 3 << 16, 5 << 16, 10 << 16, 20 << 16, 32, 8, 256, 0));
    pending_sprites.push_back(mk(1, -(3 << 16), 7, 10 << 16, -(20 << 16), 8, 40, 384, 16'h1234));
    pending_sprites.push_back(mk(0, COORD_MAX, COORD_MAX, 0, 0, 65535, 65535, 65535, 0));
    pending_sprites.push_back(mk(0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 65535, 65535,
                                 65535, 16'h6000));
    pending_sprites.push_back(mk(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 65535, 65535,
                                 65535, 16'h1234));
    pending_sprites.push_back(mk(1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 65535, 65535,
                                 65535, 16'hFFFF));
    pending_sprites.push_back(mk(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0));
    pending_sprites.push_back(mk(0, 1 << 16, 1 << 16, 0, 0, 100, 100, 0, 16'h3000));
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 0, 65535, 1, 16'hA000));
    pending_sprites.push_back(mk(0, 5 << 16, -(5 << 16), COORD_MAX, COORD_MIN, 100, 100, 256,
                                 16'h8000));
    pending_sprites.push_back(mk(1, 0, 0, 0, 0, 1, 0, 65535, 0));
    pending_sprites.push_back(mk(0, -1, -1, -1, -1, 65535, 65535, 65535, 16'hFFFF));
    pending_sprites.push_back(mk(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 65535, 1, 256,
                                 16'h4000));

    for (n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // typical sprites: modest coordinates and sizes
        s = mk($urandom_range(0, 3) == 0, near_coord(23), near_coord(23), near_coord(27),
               near_coord(27), $urandom_range(1, 1024), $urandom_range(1, 1024),
               $urandom_range(64, 1024),
               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535));
      end else if (r < 88) begin
        s = mk($urandom_range(0, 1), longint'($signed($urandom())),
               longint'($signed($urandom())), longint'($signed($urandom())),
               longint'($signed($urandom())), $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        s = mk($urandom_range(0, 1), edge_coord(), edge_coord(), edge_coord(), edge_coord(),
               edge_dim(), edge_dim(), edge_dim(),
               ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65535));
      end
      pending_sprites.push_back(s);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_sprites.size() != 0 || sprite_if.valid || expected_points.size() != 0);
    repeat (40) @(posedge clk_i);

    if (errors == 0 && expected_points.size() == 0) begin
      $display("** sprite_corner_transform_core: PASSED **");
    end else begin
      $display("** sprite_corner_transform_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("** sprite_corner_transform_core: FAILED **");
    $finish;
  end

endmodule
